/* rtl/bmis_pkg.sv */
package bmis_pkg;

    localparam int COORD_BITS     = 14;
    localparam int SIZE_BITS      = 15;
    localparam int INDEX_BITS     = 2 * COORD_BITS;
    localparam int REM_BITS       = SIZE_BITS + 1;
    localparam int CMP_BITS       = SIZE_BITS + 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    // input register, one remainder stage per coordinate bit, mirror, multiply, add
    localparam int LATENCY        = COORD_BITS + 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SEL_X       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEL_Y       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEL_W       = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEL_H       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_W     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_H     = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH = 3'd6;

    typedef struct packed {
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [7:0]            red_in;
        logic [7:0]            green_in;
        logic [7:0]            blue_in;
    } bmis_pixel_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] dest_x;
        logic [COORD_BITS-1:0] dest_y;
        logic [INDEX_BITS-1:0] dest_index;
        logic [7:0]            red_out;
        logic [7:0]            green_out;
        logic [7:0]            blue_out;
        logic                  moved;
    } bmis_result_t;

    // One slot of the remainder pipeline
    typedef struct packed {
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0] off_x;
        logic [COORD_BITS-1:0] off_y;
        logic                  ge_x;
        logic                  ge_y;
        logic [REM_BITS-1:0]   rem_x;
        logic [REM_BITS-1:0]   rem_y;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
    } bmis_div_t;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [REM_BITS-1:0] rem_step(
        input logic [REM_BITS-1:0]  rem,
        input logic                 din,
        input logic [SIZE_BITS-1:0] divisor
    );
        logic [REM_BITS-1:0] trial;
        logic [REM_BITS-1:0] dvs;
        trial = {rem[REM_BITS-2:0], din};
        dvs   = {1'b0, divisor};
        return (trial >= dvs) ? (trial - dvs) : trial;
    endfunction

endpackage

/* rtl/block_mirror_invert_scramble.sv */
// Block mirror/invert pixel scrambler. One pixel is taken on every clock while
// busy is low (busy is high only during reset and the first cycle after it);
// its result comes out as a one-cycle done strobe, in input order. The
// receiver cannot stall, so nothing is ever held back. The pipeline is the
// input register, then the remainder pipeline, which resolves one bit of
// (pos - sel) mod block per stage over 14 stages, then the mirror stage,
// the row multiply and the index add. Configuration writes
// are always accepted (cfg_ready is tied high) and take effect on the next
// clock; write them only while no pixel is in flight. A block size of 0 acts
// as 1; indexes beyond the register list are ignored.
module block_mirror_invert_scramble
    import bmis_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bmis_pixel_t               pixel,
    output logic                      done,
    output bmis_result_t              result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] sel_x_reg;
    logic [COORD_BITS-1:0] sel_y_reg;
    logic [SIZE_BITS-1:0]  sel_w_reg;
    logic [SIZE_BITS-1:0]  sel_h_reg;
    logic [SIZE_BITS-1:0]  blk_w_reg;   // hold the effective size: zero reads as one
    logic [SIZE_BITS-1:0]  blk_h_reg;
    logic [SIZE_BITS-1:0]  image_width_reg;
    logic [SIZE_BITS-1:0]  cfg_size;
    logic [SIZE_BITS-1:0]  cfg_blk;
    logic                  busy_reg;

    assign cfg_ready = 1'b1;
    assign busy      = busy_reg;
    assign cfg_size  = cfg_data[SIZE_BITS-1:0];
    assign cfg_blk   = (cfg_size == '0) ? SIZE_BITS'(1) : cfg_size;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_x_reg       <= '0;
            sel_y_reg       <= '0;
            sel_w_reg       <= '0;
            sel_h_reg       <= '0;
            blk_w_reg       <= SIZE_BITS'(8);
            blk_h_reg       <= SIZE_BITS'(8);
            image_width_reg <= SIZE_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SEL_X:       sel_x_reg       <= cfg_data[COORD_BITS-1:0];
                REG_SEL_Y:       sel_y_reg       <= cfg_data[COORD_BITS-1:0];
                REG_SEL_W:       sel_w_reg       <= cfg_size;
                REG_SEL_H:       sel_h_reg       <= cfg_size;
                REG_BLOCK_W:     blk_w_reg       <= cfg_blk;
                REG_BLOCK_H:     blk_h_reg       <= cfg_blk;
                REG_IMAGE_WIDTH: image_width_reg <= cfg_size;
                default:         ;  // drop writes past the register list
            endcase
        end
    end

    // Hold busy through reset and release it on the first clock after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Input stage and remainder pipeline
    // Stage 0 registers the offset from the selection corner; stage k+1
    // advances both remainders by one dividend bit, MSB first.
    // ------------------------------------------------------------------
    logic [COORD_BITS:0] div_vld_reg;
    logic [COORD_BITS:0] div_vld_next;
    bmis_div_t           div_reg  [COORD_BITS+1];
    bmis_div_t           div_next [COORD_BITS+1];

    assign div_vld_next = {div_vld_reg[COORD_BITS-1:0], start & ~busy};

    always_comb
    begin
        div_next[0].pos_x = pixel.pos_x;
        div_next[0].pos_y = pixel.pos_y;
        div_next[0].ge_x  = (pixel.pos_x >= sel_x_reg);
        div_next[0].ge_y  = (pixel.pos_y >= sel_y_reg);
        div_next[0].off_x = pixel.pos_x - sel_x_reg;
        div_next[0].off_y = pixel.pos_y - sel_y_reg;
        div_next[0].rem_x = '0;
        div_next[0].rem_y = '0;
        div_next[0].red   = pixel.red_in;
        div_next[0].green = pixel.green_in;
        div_next[0].blue  = pixel.blue_in;
        for (int k = 0; k < COORD_BITS; k++)
        begin
            div_next[k+1]       = div_reg[k];
            div_next[k+1].rem_x = rem_step(div_reg[k].rem_x,
                                           div_reg[k].off_x[COORD_BITS-1-k], blk_w_reg);
            div_next[k+1].rem_y = rem_step(div_reg[k].rem_y,
                                           div_reg[k].off_y[COORD_BITS-1-k], blk_h_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_vld_reg <= '0;
        else
            div_vld_reg <= div_vld_next;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= COORD_BITS; k++)
            div_reg[k] <= div_next[k];
    end

    // ------------------------------------------------------------------
    // Mirror stage
    // With r = off mod blk the mirrored coordinate is pos + blk - 1 - 2r,
    // and the pixel lies in a whole block when pos >= sel and off - r + blk <= span.
    // ------------------------------------------------------------------
    bmis_div_t             dl;
    logic [CMP_BITS-1:0]   end_x;
    logic [CMP_BITS-1:0]   end_y;
    logic                  in_x;
    logic                  in_y;
    logic [COORD_BITS-1:0] mir_x;
    logic [COORD_BITS-1:0] mir_y;
    logic                  mir_vld_reg;
    bmis_result_t          mir_reg;
    bmis_result_t          mir_next;

    assign dl    = div_reg[COORD_BITS];
    assign end_x = CMP_BITS'(dl.off_x) - CMP_BITS'(dl.rem_x) + CMP_BITS'(blk_w_reg);
    assign end_y = CMP_BITS'(dl.off_y) - CMP_BITS'(dl.rem_y) + CMP_BITS'(blk_h_reg);
    assign in_x  = dl.ge_x && (end_x <= CMP_BITS'(sel_w_reg));
    assign in_y  = dl.ge_y && (end_y <= CMP_BITS'(sel_h_reg));
    assign mir_x = dl.pos_x + COORD_BITS'(blk_w_reg - SIZE_BITS'(1))
                   - COORD_BITS'({dl.rem_x, 1'b0});
    assign mir_y = dl.pos_y + COORD_BITS'(blk_h_reg - SIZE_BITS'(1))
                   - COORD_BITS'({dl.rem_y, 1'b0});

    always_comb
    begin
        mir_next.moved      = in_x && in_y;
        mir_next.dest_x     = mir_next.moved ? mir_x : dl.pos_x;
        mir_next.dest_y     = mir_next.moved ? mir_y : dl.pos_y;
        mir_next.dest_index = '0;
        mir_next.red_out    = dl.red   ^ {8{mir_next.moved}};
        mir_next.green_out  = dl.green ^ {8{mir_next.moved}};
        mir_next.blue_out   = dl.blue  ^ {8{mir_next.moved}};
    end

    // ------------------------------------------------------------------
    // Row multiply, then index add into the output register
    // ------------------------------------------------------------------
    logic [COORD_BITS+SIZE_BITS-1:0] prod_full;
    logic                            prod_vld_reg;
    logic [INDEX_BITS-1:0]           prod_reg;
    bmis_result_t                    prod_data_reg;
    logic                            out_vld_reg;
    bmis_result_t                    out_reg;
    bmis_result_t                    out_next;

    assign prod_full = {{SIZE_BITS{1'b0}}, mir_reg.dest_y}
                     * {{COORD_BITS{1'b0}}, image_width_reg};

    always_comb
    begin
        out_next            = prod_data_reg;
        out_next.dest_index = prod_reg + INDEX_BITS'(prod_data_reg.dest_x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mir_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            mir_vld_reg  <= div_vld_reg[COORD_BITS];
            prod_vld_reg <= mir_vld_reg;
            out_vld_reg  <= prod_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mir_reg       <= mir_next;
        prod_reg      <= prod_full[INDEX_BITS-1:0];
        prod_data_reg <= mir_reg;
        out_reg       <= out_next;
    end

    assign done   = out_vld_reg;
    assign result = out_reg;

endmodule

/* rtl/bmis_checker.sv */
module bmis_checker
    import bmis_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input bmis_pixel_t               pixel,
    input logic                      done,
    input bmis_result_t              result
);

    localparam int WARM_BITS = $clog2(LATENCY + 1);

    logic [WARM_BITS-1:0] warm_cnt_reg;
    logic                 warm;

    assign warm = (warm_cnt_reg == WARM_BITS'(LATENCY));

    // Count cycles since reset until the pipeline history is all post-reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            warm_cnt_reg <= '0;
        else if (!warm)
            warm_cnt_reg <= warm_cnt_reg + WARM_BITS'(1);
    end

    // One result per accepted pixel, a fixed latency later
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        warm |-> (done == $past(start && !busy, LATENCY)))
        else $error("result strobe does not match an accepted pixel");

    // Unmoved pixels keep position and colour
    a_unmoved_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && done && !result.moved) |->
            (result.dest_x == $past(pixel.pos_x, LATENCY)) &&
            (result.dest_y == $past(pixel.pos_y, LATENCY)) &&
            (result.red_out == $past(pixel.red_in, LATENCY)) &&
            (result.green_out == $past(pixel.green_in, LATENCY)) &&
            (result.blue_out == $past(pixel.blue_in, LATENCY)))
        else $error("unmoved pixel changed");

    // Moved pixels have every colour byte inverted
    a_moved_inverts: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && done && result.moved) |->
            (result.red_out == ~$past(pixel.red_in, LATENCY)) &&
            (result.green_out == ~$past(pixel.green_in, LATENCY)) &&
            (result.blue_out == ~$past(pixel.blue_in, LATENCY)))
        else $error("moved pixel colour not inverted");

    // Once released after reset, busy stays low
    a_busy_released: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose outside reset");

endmodule

bind block_mirror_invert_scramble bmis_checker u_bmis_checker (.*);
